FILE: rtl/core/etu_pkg.sv
// Shared types, codes and byte classification for the expression tokenizer.
// Used by etu_front, etu_queue, etu_back and expression_tokenizer_unit.
// No dependencies.
package etu_pkg;

	localparam int MAX_TEXT_LEN = 4096;
	localparam int POS_W        = $clog2(MAX_TEXT_LEN) + 1;
	localparam int START_W      = 12;
	localparam int LEN_W        = 13;
	localparam int START_MAX    = MAX_TEXT_LEN - 1;
	localparam int BURST_MAX    = 4;
	localparam int QDEPTH       = 4;

	typedef logic [POS_W-1:0] pos_t;

	// token kinds
	localparam logic [2:0] K_NUMBER = 3'd0;
	localparam logic [2:0] K_IDENT  = 3'd1;
	localparam logic [2:0] K_OPER   = 3'd2;
	localparam logic [2:0] K_LPAREN = 3'd3;
	localparam logic [2:0] K_RPAREN = 3'd4;
	localparam logic [2:0] K_COMMA  = 3'd5;
	localparam logic [2:0] K_END    = 3'd6;

	// operator codes
	localparam logic [2:0] OP_PLUS  = 3'd0;
	localparam logic [2:0] OP_MINUS = 3'd1;
	localparam logic [2:0] OP_TIMES = 3'd2;
	localparam logic [2:0] OP_DIV   = 3'd3;
	localparam logic [2:0] OP_POW   = 3'd4;
	localparam logic [2:0] OP_FACT  = 3'd5;

	// error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_NUMBER = 2'd1;
	localparam logic [1:0] ERR_CHAR   = 2'd2;

	// bytes of interest
	localparam logic [7:0] B_LEAD2  = 8'hC3;
	localparam logic [7:0] B_TIMES  = 8'h97;
	localparam logic [7:0] B_DIV    = 8'hB7;
	localparam logic [7:0] B_LEAD3  = 8'hE2;
	localparam logic [7:0] B_MID3   = 8'h88;
	localparam logic [7:0] B_ROOT   = 8'h9A;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_EU    = 8'h45;
	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LP    = 8'h28;
	localparam logic [7:0] CH_RP    = 8'h29;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	typedef enum logic [9:0] {
		MD_IDLE    = 10'b00_0000_0001,
		MD_LEAD2   = 10'b00_0000_0010,
		MD_LEAD3   = 10'b00_0000_0100,
		MD_MID3    = 10'b00_0000_1000,
		MD_NUM     = 10'b00_0001_0000,
		MD_EXP     = 10'b00_0010_0000,
		MD_EXPSIGN = 10'b00_0100_0000,
		MD_EXPDIG  = 10'b00_1000_0000,
		MD_IDENT   = 10'b01_0000_0000,
		MD_DROP    = 10'b10_0000_0000
	} mode_t;

	typedef struct packed {
		logic [1:0]         err;
		logic [LEN_W-1:0]   len;
		logic [START_W-1:0] start;
		logic               root;
		logic [2:0]         op;
		logic [2:0]         kind;
	} res_t;

	// results caused by one input byte, first in res[0]
	typedef struct packed {
		logic [2:0]           cnt;
		res_t [BURST_MAX-1:0] res;
	} burst_t;

	function automatic logic is_space(input logic [7:0] b);
		return b inside {8'd32, [8'd9:8'd13]};
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return b inside {[8'h61:8'h7A], [8'h41:8'h5A]};
	endfunction

	function automatic logic is_word(input logic [7:0] b);
		return is_alpha(b) || is_digit(b) || (b == CH_US);
	endfunction

	function automatic logic is_oper(input logic [7:0] b);
		return b inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_BANG};
	endfunction

	function automatic logic [2:0] oper_of(input logic [7:0] b);
		logic [2:0] c;
		case (b)
			CH_MINUS: c = OP_MINUS;
			CH_STAR:  c = OP_TIMES;
			CH_SLASH: c = OP_DIV;
			CH_CARET: c = OP_POW;
			CH_BANG:  c = OP_FACT;
			default:  c = OP_PLUS;
		endcase
		return c;
	endfunction

	function automatic pos_t span(input pos_t from, input pos_t upto);
		return (upto > from) ? pos_t'(upto - from) : '0;
	endfunction

	// position of the held 'e' when an exponent is backed off
	function automatic pos_t back_pos(input pos_t nxt, input logic [1:0] held, input pos_t ts);
		pos_t e;
		e = (nxt >= pos_t'(held)) ? pos_t'(nxt - pos_t'(held)) : '0;
		if (e < ts) e = ts;
		return e;
	endfunction

	function automatic res_t mk_res(input logic [2:0] kind, input logic [2:0] op,
			input logic root, input pos_t start, input pos_t len, input logic [1:0] err);
		res_t r;
		r.kind  = kind;
		r.op    = op;
		r.root  = root;
		r.start = (start > pos_t'(START_MAX)) ? START_W'(START_MAX) : start[START_W-1:0];
		r.len   = (len > pos_t'(MAX_TEXT_LEN)) ? LEN_W'(MAX_TEXT_LEN) : LEN_W'(len);
		r.err   = err;
		return r;
	endfunction

endpackage

FILE: rtl/core/etu_front.sv
// Front end of the tokenizer: takes one text byte per transfer, runs the lexer
// state machine and pushes the burst of tokens it completes into the queue.
// Depends on etu_pkg.
module etu_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	output logic            in_ready,
	input  logic            q_full,
	output logic            q_push,
	output etu_pkg::burst_t q_wdata
);

	etu_pkg::mode_t mode_q;
	etu_pkg::pos_t  tstart_q;
	etu_pkg::pos_t  pos_q;
	logic           digit_q;
	logic           dot_q;
	logic [1:0]     held_q;
	logic [2:0]     sign_q;
	logic           spill_vld_q;
	etu_pkg::res_t  spill_q;

	etu_pkg::mode_t md;
	etu_pkg::pos_t  ts;
	etu_pkg::pos_t  pos_n;
	etu_pkg::pos_t  p;
	etu_pkg::pos_t  np;
	etu_pkg::pos_t  epos;
	logic           sd;
	logic           sdot;
	logic [1:0]     hc;
	logic [2:0]     sg;
	logic           busy;
	logic [2:0]     cnt;
	etu_pkg::res_t  lst [6];
	logic           acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	always_comb begin
		md   = mode_q;
		ts   = tstart_q;
		sd   = digit_q;
		sdot = dot_q;
		hc   = held_q;
		sg   = sign_q;
		epos = '0;
		cnt  = '0;
		for (int i = 0; i < 6; i++) lst[i] = '0;
		if (spill_vld_q) begin
			lst[0] = spill_q;
			cnt    = 3'd1;
		end
		p     = pos_q;
		np    = (pos_q < etu_pkg::pos_t'(etu_pkg::MAX_TEXT_LEN)) ?
			etu_pkg::pos_t'(pos_q + etu_pkg::pos_t'(1)) : pos_q;
		pos_n = np;
		busy  = 1'b1;

		// a byte can close a token, back off an exponent and then start a new token
		for (int s = 0; s < 3; s++) begin
			if (busy) begin
				busy = 1'b0;
				case (md)
					etu_pkg::MD_IDLE: begin
						ts = p;
						if (etu_pkg::is_space(in_byte)) begin
						end else if (in_byte == etu_pkg::B_LEAD2) begin
							md = etu_pkg::MD_LEAD2;
						end else if (in_byte == etu_pkg::B_LEAD3) begin
							md = etu_pkg::MD_LEAD3;
						end else if (etu_pkg::is_digit(in_byte) || in_byte == etu_pkg::CH_DOT) begin
							md   = etu_pkg::MD_NUM;
							sd   = etu_pkg::is_digit(in_byte);
							sdot = (in_byte == etu_pkg::CH_DOT);
						end else if (etu_pkg::is_alpha(in_byte) || in_byte == etu_pkg::CH_US) begin
							md = etu_pkg::MD_IDENT;
						end else if (etu_pkg::is_oper(in_byte)) begin
							lst[cnt] = etu_pkg::mk_res(etu_pkg::K_OPER, etu_pkg::oper_of(in_byte),
								1'b0, p, etu_pkg::pos_t'(1), etu_pkg::ERR_NONE);
							cnt = cnt + 3'd1;
						end else if (in_byte == etu_pkg::CH_LP) begin
							lst[cnt] = etu_pkg::mk_res(etu_pkg::K_LPAREN, etu_pkg::OP_PLUS,
								1'b0, p, etu_pkg::pos_t'(1), etu_pkg::ERR_NONE);
							cnt = cnt + 3'd1;
						end else if (in_byte == etu_pkg::CH_RP) begin
							lst[cnt] = etu_pkg::mk_res(etu_pkg::K_RPAREN, etu_pkg::OP_PLUS,
								1'b0, p, etu_pkg::pos_t'(1), etu_pkg::ERR_NONE);
							cnt = cnt + 3'd1;
						end else if (in_byte == etu_pkg::CH_COMMA) begin
							lst[cnt] = etu_pkg::mk_res(etu_pkg::K_COMMA, etu_pkg::OP_PLUS,
								1'b0, p, etu_pkg::pos_t'(1), etu_pkg::ERR_NONE);
							cnt = cnt + 3'd1;
						end else begin
							lst[cnt] = etu_pkg::mk_res(etu_pkg::K_END, etu_pkg::OP_PLUS,
								1'b0, p, etu_pkg::pos_t'(1), etu_pkg::ERR_CHAR);
							cnt = cnt + 3'd1;
							md  = etu_pkg::MD_DROP;
						end
					end
					etu_pkg::MD_LEAD2: begin
						if (in_byte == etu_pkg::B_TIMES || in_byte == etu_pkg::B_DIV) begin
							lst[cnt] = etu_pkg::mk_res(etu_pkg::K_OPER,
								(in_byte == etu_pkg::B_TIMES) ? etu_pkg::OP_TIMES : etu_pkg::OP_DIV,
								1'b0, ts, etu_pkg::pos_t'(2), etu_pkg::ERR_NONE);
							cnt = cnt + 3'd1;
							md  = etu_pkg::MD_IDLE;
						end else begin
							lst[cnt] = etu_pkg::mk_res(etu_pkg::K_END, etu_pkg::OP_PLUS,
								1'b0, ts, etu_pkg::pos_t'(1), etu_pkg::ERR_CHAR);
							cnt = cnt + 3'd1;
							md  = etu_pkg::MD_DROP;
						end
					end
					etu_pkg::MD_LEAD3: begin
						if (in_byte == etu_pkg::B_MID3) begin
							md = etu_pkg::MD_MID3;
						end else begin
							lst[cnt] = etu_pkg::mk_res(etu_pkg::K_END, etu_pkg::OP_PLUS,
								1'b0, ts, etu_pkg::pos_t'(1), etu_pkg::ERR_CHAR);
							cnt = cnt + 3'd1;
							md  = etu_pkg::MD_DROP;
						end
					end
					etu_pkg::MD_MID3: begin
						if (in_byte == etu_pkg::B_ROOT) begin
							lst[cnt] = etu_pkg::mk_res(etu_pkg::K_IDENT, etu_pkg::OP_PLUS,
								1'b1, ts, etu_pkg::pos_t'(3), etu_pkg::ERR_NONE);
							cnt = cnt + 3'd1;
							md  = etu_pkg::MD_IDLE;
						end else begin
							lst[cnt] = etu_pkg::mk_res(etu_pkg::K_END, etu_pkg::OP_PLUS,
								1'b0, ts, etu_pkg::pos_t'(1), etu_pkg::ERR_CHAR);
							cnt = cnt + 3'd1;
							md  = etu_pkg::MD_DROP;
						end
					end
					etu_pkg::MD_NUM: begin
						if (etu_pkg::is_digit(in_byte)) begin
							sd = 1'b1;
						end else if (in_byte == etu_pkg::CH_DOT && !sdot) begin
							sdot = 1'b1;
						end else if (!sd) begin
							lst[cnt] = etu_pkg::mk_res(etu_pkg::K_END, etu_pkg::OP_PLUS,
								1'b0, ts, etu_pkg::pos_t'(1), etu_pkg::ERR_NUMBER);
							cnt = cnt + 3'd1;
							md  = etu_pkg::MD_DROP;
						end else if (in_byte == etu_pkg::CH_E || in_byte == etu_pkg::CH_EU) begin
							hc = 2'd1;
							md = etu_pkg::MD_EXP;
						end else begin
							lst[cnt] = etu_pkg::mk_res(etu_pkg::K_NUMBER, etu_pkg::OP_PLUS,
								1'b0, ts, etu_pkg::span(ts, p), etu_pkg::ERR_NONE);
							cnt  = cnt + 3'd1;
							md   = etu_pkg::MD_IDLE;
							busy = 1'b1;
						end
					end
					etu_pkg::MD_EXP, etu_pkg::MD_EXPSIGN: begin
						if (etu_pkg::is_digit(in_byte)) begin
							hc = 2'd0;
							md = etu_pkg::MD_EXPDIG;
						end else if (md == etu_pkg::MD_EXP &&
								(in_byte == etu_pkg::CH_PLUS || in_byte == etu_pkg::CH_MINUS)) begin
							sg = etu_pkg::oper_of(in_byte);
							hc = 2'd2;
							md = etu_pkg::MD_EXPSIGN;
						end else begin
							// exponent without digits: number ends before the 'e'
							epos = etu_pkg::back_pos(p, hc, ts);
							lst[cnt] = etu_pkg::mk_res(etu_pkg::K_NUMBER, etu_pkg::OP_PLUS,
								1'b0, ts, etu_pkg::pos_t'(epos - ts), etu_pkg::ERR_NONE);
							cnt = cnt + 3'd1;
							if (hc == 2'd2) begin
								lst[cnt] = etu_pkg::mk_res(etu_pkg::K_IDENT, etu_pkg::OP_PLUS,
									1'b0, epos, etu_pkg::pos_t'(1), etu_pkg::ERR_NONE);
								cnt = cnt + 3'd1;
								lst[cnt] = etu_pkg::mk_res(etu_pkg::K_OPER, sg, 1'b0,
									etu_pkg::pos_t'(epos + etu_pkg::pos_t'(1)),
									etu_pkg::pos_t'(1), etu_pkg::ERR_NONE);
								cnt = cnt + 3'd1;
								md  = etu_pkg::MD_IDLE;
							end else begin
								ts = epos;
								md = etu_pkg::MD_IDENT;
							end
							hc   = 2'd0;
							busy = 1'b1;
						end
					end
					etu_pkg::MD_EXPDIG: begin
						if (!etu_pkg::is_digit(in_byte)) begin
							lst[cnt] = etu_pkg::mk_res(etu_pkg::K_NUMBER, etu_pkg::OP_PLUS,
								1'b0, ts, etu_pkg::span(ts, p), etu_pkg::ERR_NONE);
							cnt  = cnt + 3'd1;
							md   = etu_pkg::MD_IDLE;
							busy = 1'b1;
						end
					end
					etu_pkg::MD_IDENT: begin
						if (!etu_pkg::is_word(in_byte)) begin
							lst[cnt] = etu_pkg::mk_res(etu_pkg::K_IDENT, etu_pkg::OP_PLUS,
								1'b0, ts, etu_pkg::span(ts, p), etu_pkg::ERR_NONE);
							cnt  = cnt + 3'd1;
							md   = etu_pkg::MD_IDLE;
							busy = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end

		// end of text: close token, add end token unless dropping, clear scan
		if (in_last) begin
			case (md)
				etu_pkg::MD_LEAD2, etu_pkg::MD_LEAD3, etu_pkg::MD_MID3: begin
					lst[cnt] = etu_pkg::mk_res(etu_pkg::K_END, etu_pkg::OP_PLUS,
						1'b0, ts, etu_pkg::pos_t'(1), etu_pkg::ERR_CHAR);
					cnt = cnt + 3'd1;
					md  = etu_pkg::MD_DROP;
				end
				etu_pkg::MD_NUM: begin
					if (sd) begin
						lst[cnt] = etu_pkg::mk_res(etu_pkg::K_NUMBER, etu_pkg::OP_PLUS,
							1'b0, ts, etu_pkg::span(ts, np), etu_pkg::ERR_NONE);
					end else begin
						lst[cnt] = etu_pkg::mk_res(etu_pkg::K_END, etu_pkg::OP_PLUS,
							1'b0, ts, etu_pkg::pos_t'(1), etu_pkg::ERR_NUMBER);
						md = etu_pkg::MD_DROP;
					end
					cnt = cnt + 3'd1;
				end
				etu_pkg::MD_EXP, etu_pkg::MD_EXPSIGN: begin
					epos = etu_pkg::back_pos(np, hc, ts);
					lst[cnt] = etu_pkg::mk_res(etu_pkg::K_NUMBER, etu_pkg::OP_PLUS,
						1'b0, ts, etu_pkg::pos_t'(epos - ts), etu_pkg::ERR_NONE);
					cnt = cnt + 3'd1;
					if (hc == 2'd2) begin
						lst[cnt] = etu_pkg::mk_res(etu_pkg::K_IDENT, etu_pkg::OP_PLUS,
							1'b0, epos, etu_pkg::pos_t'(1), etu_pkg::ERR_NONE);
						cnt = cnt + 3'd1;
						lst[cnt] = etu_pkg::mk_res(etu_pkg::K_OPER, sg, 1'b0,
							etu_pkg::pos_t'(epos + etu_pkg::pos_t'(1)),
							etu_pkg::pos_t'(1), etu_pkg::ERR_NONE);
						cnt = cnt + 3'd1;
					end else begin
						lst[cnt] = etu_pkg::mk_res(etu_pkg::K_IDENT, etu_pkg::OP_PLUS,
							1'b0, epos, etu_pkg::span(epos, np), etu_pkg::ERR_NONE);
						cnt = cnt + 3'd1;
					end
					md = etu_pkg::MD_IDLE;
				end
				etu_pkg::MD_EXPDIG: begin
					lst[cnt] = etu_pkg::mk_res(etu_pkg::K_NUMBER, etu_pkg::OP_PLUS,
						1'b0, ts, etu_pkg::span(ts, np), etu_pkg::ERR_NONE);
					cnt = cnt + 3'd1;
				end
				etu_pkg::MD_IDENT: begin
					lst[cnt] = etu_pkg::mk_res(etu_pkg::K_IDENT, etu_pkg::OP_PLUS,
						1'b0, ts, etu_pkg::span(ts, np), etu_pkg::ERR_NONE);
					cnt = cnt + 3'd1;
				end
				default: begin
				end
			endcase
			if (md != etu_pkg::MD_DROP) begin
				lst[cnt] = etu_pkg::mk_res(etu_pkg::K_END, etu_pkg::OP_PLUS,
					1'b0, np, '0, etu_pkg::ERR_NONE);
				cnt = cnt + 3'd1;
			end
			md    = etu_pkg::MD_IDLE;
			ts    = '0;
			pos_n = '0;
			sd    = 1'b0;
			sdot  = 1'b0;
			hc    = 2'd0;
		end
	end

	assign q_push        = acc && (cnt != 3'd0);
	assign q_wdata.cnt   = (cnt > 3'(etu_pkg::BURST_MAX)) ? 3'(etu_pkg::BURST_MAX) : cnt;
	assign q_wdata.res[0] = lst[0];
	assign q_wdata.res[1] = lst[1];
	assign q_wdata.res[2] = lst[2];
	assign q_wdata.res[3] = lst[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= etu_pkg::MD_IDLE;
			tstart_q    <= '0;
			pos_q       <= '0;
			digit_q     <= 1'b0;
			dot_q       <= 1'b0;
			held_q      <= 2'd0;
			spill_vld_q <= 1'b0;
		end else if (acc) begin
			mode_q      <= md;
			tstart_q    <= ts;
			pos_q       <= pos_n;
			digit_q     <= sd;
			dot_q       <= sdot;
			held_q      <= hc;
			// a fifth token waits for the next byte's transfer
			spill_vld_q <= (cnt > 3'(etu_pkg::BURST_MAX));
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sign_q  <= sg;
			spill_q <= lst[4];
		end
	end

endmodule

FILE: rtl/core/etu_queue.sv
// Short FIFO of token bursts between the lexer front end and the output stage.
// Depends on etu_pkg.
module etu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  etu_pkg::burst_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            vld,
	output etu_pkg::burst_t rdata
);

	localparam int AW = $clog2(etu_pkg::QDEPTH);

	etu_pkg::burst_t mem_q [etu_pkg::QDEPTH];
	logic [AW-1:0]   wp_q;
	logic [AW-1:0]   rp_q;
	logic [AW:0]     cnt_q;
	logic            do_pop;

	assign full   = (cnt_q == (AW+1)'(etu_pkg::QDEPTH));
	assign vld    = (cnt_q != '0);
	assign rdata  = mem_q[rp_q];
	assign do_pop = pop && vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + AW'(1);
			if (do_pop) rp_q <= rp_q + AW'(1);
			if (push && !do_pop) cnt_q <= cnt_q + (AW+1)'(1);
			else if (do_pop && !push) cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

endmodule

FILE: rtl/core/etu_back.sv
// Output stage: unpacks one burst at a time and drives one token per transfer
// from an output register, marking the burst's final token.
// Depends on etu_pkg.
module etu_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_vld,
	input  etu_pkg::burst_t q_rdata,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output etu_pkg::res_t   out_res,
	output logic            out_last
);

	etu_pkg::burst_t bur_q;
	logic            bur_vld_q;
	logic [1:0]      idx_q;
	logic            vld_q;
	etu_pkg::res_t   res_q;
	logic            last_q;
	logic            adv;
	logic            move;
	logic            last_item;

	assign adv       = !vld_q || out_ready;
	assign move      = adv && bur_vld_q;
	assign last_item = ((3'(idx_q) + 3'd1) == bur_q.cnt);
	assign q_pop     = q_vld && (!bur_vld_q || (move && last_item));

	assign out_valid = vld_q;
	assign out_res   = res_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= 1'b0;
			bur_vld_q <= 1'b0;
			idx_q     <= 2'd0;
		end else begin
			if (move) vld_q <= 1'b1;
			else if (adv) vld_q <= 1'b0;
			if (q_pop) begin
				bur_vld_q <= 1'b1;
				idx_q     <= 2'd0;
			end else if (move && last_item) begin
				bur_vld_q <= 1'b0;
			end else if (move) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) bur_q <= q_rdata;
		if (move) begin
			res_q  <= bur_q.res[idx_q];
			last_q <= last_item;
		end
	end

endmodule

FILE: rtl/core/expression_tokenizer_unit.sv
// Expression tokenizer, top level. The first token caused by a byte passes from
// the queue through the burst register into the output register. Input takes
// one byte per cycle; tokens drain one per cycle while the sink is ready, and a
// 4-burst queue stalls input when token bursts outrun the output. A fifth token
// of an end-of-text burst comes out after the next byte's transfer. Reset (arst_n low,
// asynchronous) clears the scan state, the queue and the output register.
module expression_tokenizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] operator_code, [3] root_sign, [15:4] start_pos, [28:16] token_len,
	// [30:29] error_code, [31] zero
	output logic [31:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser,   // [2:0] token_kind
	output logic        m_axis_tlast
);

	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_vld;
	etu_pkg::burst_t q_wdata;
	etu_pkg::burst_t q_rdata;
	etu_pkg::res_t   out_res;

	etu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	etu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.vld    (q_vld),
		.rdata  (q_rdata)
	);

	etu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_vld     (q_vld),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_res.err, out_res.len, out_res.start, out_res.root, out_res.op};
	assign m_axis_tuser = out_res.kind;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("burst pushed into a full queue");

	a_error_token: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_res.err != etu_pkg::ERR_NONE |->
			out_res.kind == etu_pkg::K_END && out_res.len == 13'd1)
		else $error("error transfer is not a one-byte end token");

	a_root_ident: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_res.root |->
			out_res.kind == etu_pkg::K_IDENT && out_res.len == 13'd3)
		else $error("root sign on a token other than a three-byte identifier");
`endif

endmodule

FILE: test/expression_tokenizer_unit_tb.sv
// Self-checking testbench for expression_tokenizer_unit: a table of directed bytes,
// then random expressions in four phases of source idling and sink stalls.
// Depends on etu_pkg and the expression_tokenizer_unit RTL.
module expression_tokenizer_unit_tb;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  op;
		logic        root;
		logic [11:0] start;
		logic [12:0] len;
		logic [1:0]  err;
		logic        last;
	} token_t;

	typedef struct packed {
		logic [7:0] b;
		logic       eot;
		logic       known;
		token_t     tok;
	} row_t;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int BURST_SLOTS  = 6;
	localparam int PHASE_BYTES  = 30;
	localparam int SRC_IDLE [4] = '{0, 48, 0, 17};
	localparam int SINK_STALL[4] = '{0, 0, 48, 17};
	localparam logic [7:0] OP_CHARS [6] = '{etu_pkg::CH_PLUS, etu_pkg::CH_MINUS,
		etu_pkg::CH_STAR, etu_pkg::CH_SLASH, etu_pkg::CH_CARET, etu_pkg::CH_BANG};
	localparam logic [7:0] PUNCT [3] = '{etu_pkg::CH_LP, etu_pkg::CH_RP, etu_pkg::CH_COMMA};

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	expression_tokenizer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	token_t expected_tokens[$];
	token_t step_tokens[$];
	int     mismatches     = 0;
	int     tokens_seen    = 0;
	int     cycle_count    = 0;
	int     src_idle_pct   = 0;
	int     sink_stall_pct = 0;
	row_t   dir_tab [28];

	// lexer state mirror
	etu_pkg::mode_t scan      = etu_pkg::MD_IDLE;
	int unsigned    tok_start = 0;
	int unsigned    byte_pos  = 0;
	bit             saw_digit = 0;
	bit             saw_dot   = 0;
	logic [7:0]     held [2]  = '{8'h00, 8'h00};
	int unsigned    held_n    = 0;
	bit             dropping  = 0;
	bit             spill_on  = 0;
	token_t         spill_tok = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at token %0d: %s got %0h want %0h", tokens_seen, what, got, want);
		mismatches++;
	endtask

	function automatic int op_index(input logic [7:0] b);
		case (b)
			etu_pkg::CH_PLUS:  return 0;
			etu_pkg::CH_MINUS: return 1;
			etu_pkg::CH_STAR:  return 2;
			etu_pkg::CH_SLASH: return 3;
			etu_pkg::CH_CARET: return 4;
			etu_pkg::CH_BANG:  return 5;
			default:           return -1;
		endcase
	endfunction

	function automatic bit blank(input logic [7:0] b);
		return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic bit digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic bit letter(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
	endfunction

	function automatic int unsigned distance(input int unsigned from, input int unsigned upto);
		return upto > from ? upto - from : 0;
	endfunction

	function automatic void add_token(input logic [2:0] kind, input logic [2:0] op,
			input logic root, input int unsigned start, input int unsigned len,
			input logic [1:0] err);
		token_t t;
		if (step_tokens.size() >= BURST_SLOTS) return;
		if (start > etu_pkg::START_MAX) start = etu_pkg::START_MAX;
		if (len > etu_pkg::MAX_TEXT_LEN) len = etu_pkg::MAX_TEXT_LEN;
		t.kind  = kind;
		t.op    = op;
		t.root  = root;
		t.start = 12'(start);
		t.len   = 13'(len);
		t.err   = err;
		t.last  = 1'b0;
		step_tokens = {step_tokens, t};
	endfunction

	function automatic void flag_error(input logic [1:0] code, input int unsigned start);
		add_token(etu_pkg::K_END, etu_pkg::OP_PLUS, 1'b0, start, 1, code);
		scan     = etu_pkg::MD_DROP;
		dropping = 1'b1;
	endfunction

	function automatic void open_token(input logic [7:0] b, input int unsigned p);
		int op;
		op = op_index(b);
		tok_start = p;
		if (blank(b)) return;
		if (b == etu_pkg::B_LEAD2) begin
			scan = etu_pkg::MD_LEAD2;
		end else if (b == etu_pkg::B_LEAD3) begin
			scan = etu_pkg::MD_LEAD3;
		end else if (digit(b) || b == etu_pkg::CH_DOT) begin
			scan      = etu_pkg::MD_NUM;
			saw_digit = digit(b);
			saw_dot   = (b == etu_pkg::CH_DOT);
		end else if (letter(b) || b == etu_pkg::CH_US) begin
			scan = etu_pkg::MD_IDENT;
		end else if (op >= 0) begin
			add_token(etu_pkg::K_OPER, 3'(op), 1'b0, p, 1, etu_pkg::ERR_NONE);
		end else if (b == etu_pkg::CH_LP) begin
			add_token(etu_pkg::K_LPAREN, etu_pkg::OP_PLUS, 1'b0, p, 1, etu_pkg::ERR_NONE);
		end else if (b == etu_pkg::CH_RP) begin
			add_token(etu_pkg::K_RPAREN, etu_pkg::OP_PLUS, 1'b0, p, 1, etu_pkg::ERR_NONE);
		end else if (b == etu_pkg::CH_COMMA) begin
			add_token(etu_pkg::K_COMMA, etu_pkg::OP_PLUS, 1'b0, p, 1, etu_pkg::ERR_NONE);
		end else begin
			flag_error(etu_pkg::ERR_CHAR, p);
		end
	endfunction

	// exponent with no digit: number ends before the 'e', which opens an identifier
	function automatic void retreat_exponent(input int unsigned nxt);
		int unsigned epos;
		int op;
		epos = nxt >= held_n ? nxt - held_n : 0;
		if (epos < tok_start) epos = tok_start;
		add_token(etu_pkg::K_NUMBER, etu_pkg::OP_PLUS, 1'b0, tok_start, epos - tok_start,
			etu_pkg::ERR_NONE);
		if (held_n == 2) begin
			op = op_index(held[1]);
			add_token(etu_pkg::K_IDENT, etu_pkg::OP_PLUS, 1'b0, epos, 1, etu_pkg::ERR_NONE);
			add_token(etu_pkg::K_OPER, op >= 0 ? 3'(op) : etu_pkg::OP_PLUS, 1'b0, epos + 1, 1,
				etu_pkg::ERR_NONE);
			scan = etu_pkg::MD_IDLE;
		end else begin
			tok_start = epos;
			scan      = etu_pkg::MD_IDENT;
		end
		held_n = 0;
	endfunction

	function automatic void scan_byte(input logic [7:0] b, input int unsigned p);
		bit again;
		do begin
			again = 1'b0;
			case (scan)
				etu_pkg::MD_IDLE: open_token(b, p);
				etu_pkg::MD_LEAD2: begin
					if (b == etu_pkg::B_TIMES || b == etu_pkg::B_DIV) begin
						add_token(etu_pkg::K_OPER,
							b == etu_pkg::B_TIMES ? etu_pkg::OP_TIMES : etu_pkg::OP_DIV,
							1'b0, tok_start, 2, etu_pkg::ERR_NONE);
						scan = etu_pkg::MD_IDLE;
					end else begin
						flag_error(etu_pkg::ERR_CHAR, tok_start);
					end
				end
				etu_pkg::MD_LEAD3: begin
					if (b == etu_pkg::B_MID3) scan = etu_pkg::MD_MID3;
					else flag_error(etu_pkg::ERR_CHAR, tok_start);
				end
				etu_pkg::MD_MID3: begin
					if (b == etu_pkg::B_ROOT) begin
						add_token(etu_pkg::K_IDENT, etu_pkg::OP_PLUS, 1'b1, tok_start, 3,
							etu_pkg::ERR_NONE);
						scan = etu_pkg::MD_IDLE;
					end else begin
						flag_error(etu_pkg::ERR_CHAR, tok_start);
					end
				end
				etu_pkg::MD_NUM: begin
					if (digit(b)) begin
						saw_digit = 1'b1;
					end else if (b == etu_pkg::CH_DOT && !saw_dot) begin
						saw_dot = 1'b1;
					end else if (!saw_digit) begin
						flag_error(etu_pkg::ERR_NUMBER, tok_start);
					end else if (b == etu_pkg::CH_E || b == etu_pkg::CH_EU) begin
						held[0] = b;
						held_n  = 1;
						scan    = etu_pkg::MD_EXP;
					end else begin
						add_token(etu_pkg::K_NUMBER, etu_pkg::OP_PLUS, 1'b0, tok_start,
							distance(tok_start, p), etu_pkg::ERR_NONE);
						scan  = etu_pkg::MD_IDLE;
						again = 1'b1;
					end
				end
				etu_pkg::MD_EXP, etu_pkg::MD_EXPSIGN: begin
					if (digit(b)) begin
						held_n = 0;
						scan   = etu_pkg::MD_EXPDIG;
					end else if (scan == etu_pkg::MD_EXP &&
							(b == etu_pkg::CH_PLUS || b == etu_pkg::CH_MINUS)) begin
						held[1] = b;
						held_n  = 2;
						scan    = etu_pkg::MD_EXPSIGN;
					end else begin
						retreat_exponent(p);
						again = 1'b1;
					end
				end
				etu_pkg::MD_EXPDIG: begin
					if (!digit(b)) begin
						add_token(etu_pkg::K_NUMBER, etu_pkg::OP_PLUS, 1'b0, tok_start,
							distance(tok_start, p), etu_pkg::ERR_NONE);
						scan  = etu_pkg::MD_IDLE;
						again = 1'b1;
					end
				end
				etu_pkg::MD_IDENT: begin
					if (!(letter(b) || digit(b) || b == etu_pkg::CH_US)) begin
						add_token(etu_pkg::K_IDENT, etu_pkg::OP_PLUS, 1'b0, tok_start,
							distance(tok_start, p), etu_pkg::ERR_NONE);
						scan  = etu_pkg::MD_IDLE;
						again = 1'b1;
					end
				end
				default: ;
			endcase
		end while (again);
	endfunction

	function automatic void close_text();
		case (scan)
			etu_pkg::MD_LEAD2, etu_pkg::MD_LEAD3, etu_pkg::MD_MID3:
				flag_error(etu_pkg::ERR_CHAR, tok_start);
			etu_pkg::MD_NUM: begin
				if (saw_digit)
					add_token(etu_pkg::K_NUMBER, etu_pkg::OP_PLUS, 1'b0, tok_start,
						distance(tok_start, byte_pos), etu_pkg::ERR_NONE);
				else
					flag_error(etu_pkg::ERR_NUMBER, tok_start);
			end
			etu_pkg::MD_EXP, etu_pkg::MD_EXPSIGN: begin
				retreat_exponent(byte_pos);
				if (scan == etu_pkg::MD_IDENT)
					add_token(etu_pkg::K_IDENT, etu_pkg::OP_PLUS, 1'b0, tok_start,
						distance(tok_start, byte_pos), etu_pkg::ERR_NONE);
			end
			etu_pkg::MD_EXPDIG: add_token(etu_pkg::K_NUMBER, etu_pkg::OP_PLUS, 1'b0, tok_start,
				distance(tok_start, byte_pos), etu_pkg::ERR_NONE);
			etu_pkg::MD_IDENT: add_token(etu_pkg::K_IDENT, etu_pkg::OP_PLUS, 1'b0, tok_start,
				distance(tok_start, byte_pos), etu_pkg::ERR_NONE);
			default: ;
		endcase
		if (!dropping)
			add_token(etu_pkg::K_END, etu_pkg::OP_PLUS, 1'b0, byte_pos, 0, etu_pkg::ERR_NONE);
		scan      = etu_pkg::MD_IDLE;
		tok_start = 0;
		byte_pos  = 0;
		saw_digit = 1'b0;
		saw_dot   = 1'b0;
		held_n    = 0;
		dropping  = 1'b0;
	endfunction

	// tokens caused by one byte; a fifth token waits for the next byte
	function automatic void lex_byte(input logic [7:0] b, input logic eot);
		int unsigned p;
		step_tokens.delete();
		if (spill_on) begin
			step_tokens = {step_tokens, spill_tok};
			spill_on = 1'b0;
		end
		p = byte_pos;
		if (byte_pos < etu_pkg::MAX_TEXT_LEN) byte_pos++;
		scan_byte(b, p);
		if (eot) close_text();
		if (step_tokens.size() > etu_pkg::BURST_MAX) begin
			spill_tok = step_tokens[etu_pkg::BURST_MAX];
			spill_on  = 1'b1;
			while (step_tokens.size() > etu_pkg::BURST_MAX) void'(step_tokens.pop_back());
		end
		if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
	endfunction

	function automatic row_t row_free(input logic [7:0] b, input logic eot);
		return '{b, eot, 1'b0, '0};
	endfunction

	function automatic row_t row_known(input logic [7:0] b, input logic eot,
			input logic [2:0] kind, input logic [2:0] op, input logic root,
			input logic [11:0] start, input logic [12:0] len, input logic [1:0] err);
		return '{b, eot, 1'b1, '{kind, op, root, start, len, err, 1'b1}};
	endfunction

	function automatic logic [7:0] digit_char();
		return 8'h30 + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] letter_char();
		return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'($urandom_range(25));
	endfunction

	task automatic send_text(input logic [7:0] b, input logic eot, input logic known,
			input token_t tok);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eot;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		lex_byte(b, eot);
		if (known) begin
			if (step_tokens.size() != 1)
				report_mismatch("table row count", step_tokens.size(), 1);
			else if (step_tokens[0] != tok)
				report_mismatch("table row token", step_tokens[0], tok);
			expected_tokens = {expected_tokens, tok};
		end else begin
			foreach (step_tokens[i]) expected_tokens = {expected_tokens, step_tokens[i]};
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (expected_tokens.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// mostly well-formed token runs, with some broken UTF-8 and raw noise
	task automatic send_expression(inout int sent);
		logic [7:0] text[$];
		int n_tok;
		int pick;
		int k;
		n_tok = $urandom_range(10, 1);
		for (k = 0; k < n_tok; k++) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				if ($urandom_range(15) == 0) begin
					text = {text, etu_pkg::CH_DOT};
				end else begin
					if ($urandom_range(7) == 0) text = {text, etu_pkg::CH_DOT};
					repeat ($urandom_range(4, 1)) text = {text, digit_char()};
					if ($urandom_range(3) == 0) begin
						text = {text, etu_pkg::CH_DOT};
						repeat ($urandom_range(3)) text = {text, digit_char()};
					end
					if ($urandom_range(2) == 0) begin
						text = {text, $urandom_range(1) ? etu_pkg::CH_E : etu_pkg::CH_EU};
						if ($urandom_range(1))
							text = {text,
								$urandom_range(1) ? etu_pkg::CH_PLUS : etu_pkg::CH_MINUS};
						if ($urandom_range(9) < 6)
							repeat ($urandom_range(3, 1)) text = {text, digit_char()};
					end
				end
			end else if (pick < 45) begin
				text = {text, $urandom_range(5) == 0 ? etu_pkg::CH_US : letter_char()};
				repeat ($urandom_range(5)) begin
					case ($urandom_range(2))
						0: text = {text, letter_char()};
						1: text = {text, digit_char()};
						default: text = {text, etu_pkg::CH_US};
					endcase
				end
			end else if (pick < 65) begin
				text = {text, OP_CHARS[$urandom_range(5)]};
			end else if (pick < 73) begin
				text = {text, PUNCT[$urandom_range(2)]};
			end else if (pick < 81) begin
				case ($urandom_range(2))
					0: text = {text, etu_pkg::B_LEAD2, etu_pkg::B_TIMES};
					1: text = {text, etu_pkg::B_LEAD2, etu_pkg::B_DIV};
					default: text = {text, etu_pkg::B_LEAD3, etu_pkg::B_MID3, etu_pkg::B_ROOT};
				endcase
			end else if (pick < 90) begin
				text = {text, $urandom_range(3) != 0 ? 8'd32 : 8'($urandom_range(13, 9))};
			end else if (pick < 95) begin
				text = {text, $urandom_range(1) ? etu_pkg::B_LEAD2 : etu_pkg::B_LEAD3};
				if (text[text.size()-1] == etu_pkg::B_LEAD3 && $urandom_range(1))
					text = {text, etu_pkg::B_MID3};
				if ($urandom_range(3) != 0) text = {text, 8'($urandom_range(255))};
			end else begin
				text = {text, 8'($urandom_range(255))};
			end
			if ($urandom_range(9) < 3) text = {text, 8'd32};
		end
		foreach (text[i]) send_text(text[i], i == text.size() - 1, 1'b0, '0);
		sent += text.size();
	endtask

	// output side: each transfer against the oldest expected token
	always @(posedge clk) begin
		token_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_tokens.size() == 0) begin
				report_mismatch("unexpected token", {m_axis_tuser, m_axis_tdata}, 0);
			end else begin
				want = expected_tokens.pop_front();
				if (m_axis_tuser != want.kind)
					report_mismatch("token_kind", m_axis_tuser, want.kind);
				if (m_axis_tdata[2:0] != want.op)
					report_mismatch("operator_code", m_axis_tdata[2:0], want.op);
				if (m_axis_tdata[3] != want.root)
					report_mismatch("root_sign", m_axis_tdata[3], want.root);
				if (m_axis_tdata[15:4] != want.start)
					report_mismatch("start_pos", m_axis_tdata[15:4], want.start);
				if (m_axis_tdata[28:16] != want.len)
					report_mismatch("token_len", m_axis_tdata[28:16], want.len);
				if (m_axis_tdata[30:29] != want.err)
					report_mismatch("error_code", m_axis_tdata[30:29], want.err);
				if (m_axis_tlast != want.last)
					report_mismatch("last_result", m_axis_tlast, want.last);
			end
			tokens_seen++;
		end
	end

	initial begin
		int ph;
		int sent;
		dir_tab = '{
			row_known(etu_pkg::CH_LP, 1'b0, etu_pkg::K_LPAREN, etu_pkg::OP_PLUS, 1'b0,
				12'd0, 13'd1, etu_pkg::ERR_NONE),
			row_known(etu_pkg::CH_RP, 1'b0, etu_pkg::K_RPAREN, etu_pkg::OP_PLUS, 1'b0,
				12'd1, 13'd1, etu_pkg::ERR_NONE),
			row_known(etu_pkg::CH_COMMA, 1'b0, etu_pkg::K_COMMA, etu_pkg::OP_PLUS, 1'b0,
				12'd2, 13'd1, etu_pkg::ERR_NONE),
			row_known(etu_pkg::CH_PLUS, 1'b0, etu_pkg::K_OPER, etu_pkg::OP_PLUS, 1'b0,
				12'd3, 13'd1, etu_pkg::ERR_NONE),
			row_known(etu_pkg::CH_MINUS, 1'b0, etu_pkg::K_OPER, etu_pkg::OP_MINUS, 1'b0,
				12'd4, 13'd1, etu_pkg::ERR_NONE),
			row_known(etu_pkg::CH_STAR, 1'b0, etu_pkg::K_OPER, etu_pkg::OP_TIMES, 1'b0,
				12'd5, 13'd1, etu_pkg::ERR_NONE),
			row_known(etu_pkg::CH_SLASH, 1'b0, etu_pkg::K_OPER, etu_pkg::OP_DIV, 1'b0,
				12'd6, 13'd1, etu_pkg::ERR_NONE),
			row_known(etu_pkg::CH_CARET, 1'b0, etu_pkg::K_OPER, etu_pkg::OP_POW, 1'b0,
				12'd7, 13'd1, etu_pkg::ERR_NONE),
			row_known(etu_pkg::CH_BANG, 1'b0, etu_pkg::K_OPER, etu_pkg::OP_FACT, 1'b0,
				12'd8, 13'd1, etu_pkg::ERR_NONE),
			row_free(etu_pkg::B_LEAD2, 1'b0),
			row_known(etu_pkg::B_TIMES, 1'b0, etu_pkg::K_OPER, etu_pkg::OP_TIMES, 1'b0,
				12'd9, 13'd2, etu_pkg::ERR_NONE),
			row_free(etu_pkg::B_LEAD2, 1'b0),
			row_known(etu_pkg::B_DIV, 1'b0, etu_pkg::K_OPER, etu_pkg::OP_DIV, 1'b0,
				12'd11, 13'd2, etu_pkg::ERR_NONE),
			row_free(etu_pkg::B_LEAD3, 1'b0),
			row_free(etu_pkg::B_MID3, 1'b0),
			row_known(etu_pkg::B_ROOT, 1'b0, etu_pkg::K_IDENT, etu_pkg::OP_PLUS, 1'b1,
				12'd13, 13'd3, etu_pkg::ERR_NONE),
			// exponent backed off after its sign, then end: five tokens, one held over
			row_free("1", 1'b0),
			row_free(etu_pkg::CH_DOT, 1'b0),
			row_free("5", 1'b0),
			row_free(etu_pkg::CH_E, 1'b0),
			row_free(etu_pkg::CH_PLUS, 1'b0),
			row_free("x", 1'b1),
			// held token comes out here; lone dot then an error drop
			row_free(etu_pkg::CH_DOT, 1'b0),
			row_known(etu_pkg::CH_PLUS, 1'b0, etu_pkg::K_END, etu_pkg::OP_PLUS, 1'b0,
				12'd0, 13'd1, etu_pkg::ERR_NUMBER),
			row_free("9", 1'b1),
			row_known(8'hFF, 1'b1, etu_pkg::K_END, etu_pkg::OP_PLUS, 1'b0,
				12'd0, 13'd1, etu_pkg::ERR_CHAR),
			row_known(etu_pkg::B_LEAD2, 1'b1, etu_pkg::K_END, etu_pkg::OP_PLUS, 1'b0,
				12'd0, 13'd1, etu_pkg::ERR_CHAR),
			row_known(8'h00, 1'b1, etu_pkg::K_END, etu_pkg::OP_PLUS, 1'b0,
				12'd0, 13'd1, etu_pkg::ERR_CHAR)
		};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i])
			send_text(dir_tab[i].b, dir_tab[i].eot, dir_tab[i].known, dir_tab[i].tok);
		s_axis_tvalid <= 1'b0;
		wait_drained();

		for (ph = 0; ph < 4; ph++) begin
			src_idle_pct   = SRC_IDLE[ph];
			sink_stall_pct = SINK_STALL[ph];
			sent = 0;
			while (sent < PHASE_BYTES) send_expression(sent);
			s_axis_tvalid <= 1'b0;
			// sender holds off until every expected transfer has come
			wait_drained();
		end
		if (spill_on) begin
			send_text(8'd32, 1'b1, 1'b0, '0);
			s_axis_tvalid <= 1'b0;
		end

		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_tokens.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
